@@ rtl/core/cvss_pkg.sv @@
// Package for the calibrated voltmeter with seven-segment display.
// Holds item types, kind codes, widths and the segment table.
// No dependencies.
package cvss_pkg;

    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 14;
    localparam int CAP_MV   = 9999;
    localparam int REF_RST  = 3000;

    localparam logic [1:0] KIND_BANDGAP = 2'd0;
    localparam logic [1:0] KIND_SAMPLE  = 2'd1;
    localparam logic [1:0] KIND_SCAN    = 2'd2;

    localparam logic [7:0] SEG_DP = 8'h80;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [3:0]      digit_enable;
        logic [7:0]      segments;
        logic [MV_W-1:0] reading_mv;
        logic            reading_new;
    } t_out_item;

    function automatic int full_scale(input int digits);
        int p;
        p = 1;
        for (int i = 0; i < digits; i++) begin
            if (p <= CAP_MV) begin
                p = p * 10;
            end
        end
        return ((p - 1) < CAP_MV) ? (p - 1) : CAP_MV;
    endfunction

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h67;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/cvss_div.sv @@
// Restoring divider: one shared compare-subtract step per cycle.
// Gives Q_W+1 quotient bits; the top bit flags a quotient of 2**Q_W or more.
// No package dependencies.
module cvss_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int Q_W   = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W:0]     o_quot
);

    localparam int DSH_W  = DEN_W + Q_W;
    localparam int CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int STEP_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [Q_W:0]      r_quot;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [CMP_W-1:0] w_a;
    logic [CMP_W-1:0] w_b;
    logic [CMP_W-1:0] w_diff;
    logic             w_ge;

    assign w_a    = CMP_W'(r_rem);
    assign w_b    = CMP_W'(r_dsh);
    assign w_ge   = (w_a >= w_b);
    assign w_diff = w_a - w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(Q_W);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {i_den, {Q_W{1'b0}}};
        end else if (r_busy) begin
            r_quot <= {r_quot[Q_W-1:0], w_ge};
            if (w_ge) begin
                r_rem <= NUM_W'(w_diff);
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ rtl/core/calibrated_voltmeter_seven_segment_top.sv @@
// Calibrated voltmeter: bandgap reference, sample averaging, decimal display scan.
// A completing sample goes through multiply, divider load, divide, digit split and
// reading emit; other items act in idle or emit a scan item. One item at a time;
// the shared compare-subtract step of the divider sets the reading time.
// Reset (synchronous, active low): reference 3000 mV, bandgap, sum, count, digits,
// scan position and reading cleared; output empty.
module calibrated_voltmeter_seven_segment_top #(
    parameter int SAMPLES  = 16,
    parameter int DIGITS   = 4,
    parameter int ADC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cvss_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cvss_pkg::t_out_item   o_out_item,
    input  logic                  i_cfg_we,
    input  logic [cvss_pkg::MV_W-1:0] i_cfg_data
);

    localparam int MV_W  = cvss_pkg::MV_W;
    localparam int SMP_W = (ADC_BITS < cvss_pkg::SAMPLE_W) ? ADC_BITS : cvss_pkg::SAMPLE_W;
    localparam int SUM_W = SMP_W + $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int NUM_W = SUM_W + MV_W;
    localparam int DEN_W = SMP_W + $clog2(SAMPLES);
    localparam int POS_W = $clog2(DIGITS);
    localparam int FULL  = cvss_pkg::full_scale(DIGITS);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL       = 3'd1;
    localparam logic [2:0] S_LOAD      = 3'd2;
    localparam logic [2:0] S_DIV       = 3'd3;
    localparam logic [2:0] S_SPLIT     = 3'd4;
    localparam logic [2:0] S_EMIT_RD   = 3'd5;
    localparam logic [2:0] S_EMIT_SCAN = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [MV_W-1:0]  r_ref;
    logic [SMP_W-1:0] r_bg, n_bg;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic [3:0]       r_digit [DIGITS];
    logic [3:0]       n_digit [DIGITS];
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_didx, n_didx;
    logic [MV_W-1:0]  r_mv, n_mv;
    logic [MV_W-1:0]  r_val, n_val;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;
    logic             r_out_valid, n_out_valid;
    cvss_pkg::t_out_item r_out_item, n_out_item;

    logic [SMP_W-1:0] w_smp;
    logic             w_out_free;
    logic             w_div_done;
    logic [MV_W:0]    w_quot;
    logic [MV_W-1:0]  w_sat;
    logic [29:0]      w_prod;
    logic [10:0]      w_q10;
    logic [MV_W-1:0]  w_ten;
    logic [MV_W-1:0]  w_rem_full;
    logic [3:0]       w_cur_digit;

    cvss_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (MV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_smp      = i_in_item.sample[SMP_W-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_sat      = (w_quot[MV_W] || (w_quot[MV_W-1:0] > MV_W'(FULL)))
                        ? MV_W'(FULL) : w_quot[MV_W-1:0];
    assign w_prod     = 30'(r_val) * 30'd52429;
    assign w_q10      = w_prod[29:19];
    assign w_ten      = MV_W'({w_q10, 3'b000}) + MV_W'({w_q10, 1'b0});
    assign w_rem_full = r_val - w_ten;
    assign w_cur_digit = r_digit[r_pos];

    always_comb begin
        n_state     = r_state;
        n_bg        = r_bg;
        n_sum       = r_sum;
        n_count     = r_count;
        n_digit     = r_digit;
        n_pos       = r_pos;
        n_didx      = r_didx;
        n_mv        = r_mv;
        n_val       = r_val;
        n_num       = r_num;
        n_den       = r_den;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.kind)
                        cvss_pkg::KIND_BANDGAP: begin
                            n_bg    = w_smp;
                            n_sum   = '0;
                            n_count = '0;
                        end
                        cvss_pkg::KIND_SAMPLE: begin
                            n_sum = r_sum + SUM_W'(w_smp);
                            if (r_count + 1'b1 == CNT_W'(SAMPLES)) begin
                                n_count = '0;
                                n_state = S_MUL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        cvss_pkg::KIND_SCAN: begin
                            n_state = S_EMIT_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                n_num   = NUM_W'(r_sum) * NUM_W'(r_ref);
                n_den   = DEN_W'(r_bg) * DEN_W'(SAMPLES);
                n_sum   = '0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_mv    = w_sat;
                    n_val   = w_sat;
                    n_didx  = '0;
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                n_digit[r_didx] = w_rem_full[3:0];
                n_val           = MV_W'(w_q10);
                if (r_didx == POS_W'(DIGITS - 1)) begin
                    n_state = S_EMIT_RD;
                end else begin
                    n_didx = r_didx + 1'b1;
                end
            end
            S_EMIT_RD: begin
                if (w_out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_item.digit_enable = '0;
                    n_out_item.segments     = '0;
                    n_out_item.reading_mv   = r_mv;
                    n_out_item.reading_new  = 1'b1;
                    n_state                 = S_IDLE;
                end
            end
            S_EMIT_SCAN: begin
                if (w_out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_item.digit_enable = 4'(32'd1 << r_pos);
                    n_out_item.segments     = cvss_pkg::seg_of(w_cur_digit)
                        | ((r_pos == POS_W'(DIGITS - 1)) ? cvss_pkg::SEG_DP : 8'h00);
                    n_out_item.reading_mv   = r_mv;
                    n_out_item.reading_new  = 1'b0;
                    n_pos   = (r_pos == POS_W'(DIGITS - 1)) ? '0 : r_pos + 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref       <= MV_W'(cvss_pkg::REF_RST);
            r_bg        <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_mv        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DIGITS; i++) begin
                r_digit[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_bg        <= n_bg;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_mv        <= n_mv;
            r_out_valid <= n_out_valid;
            r_digit     <= n_digit;
            if (i_cfg_we) begin
                r_ref <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx     <= n_didx;
        r_val      <= n_val;
        r_num      <= n_num;
        r_den      <= n_den;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
